### rtl/core/planar_uv_projection_top_assert.svh
// Assertion macros used by the planar UV projection controller.
`ifndef PLANAR_UV_PROJECTION_TOP_ASSERT_SVH
`define PLANAR_UV_PROJECTION_TOP_ASSERT_SVH

// Checked on every rising edge while out of reset.
`define UVP_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked on every rising edge, reset included.
`define UVP_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

### rtl/core/uvp_pkg.sv
package uvp_pkg;

	// Fixed field widths of the coordinate and texture formats.
	localparam int COORD_WIDTH  = 32;
	localparam int UV_FRAC_BITS = 16;
	localparam int UV_W         = UV_FRAC_BITS + 1;
	localparam int SPAN_W       = COORD_WIDTH + 1;
	localparam int CNT_W        = $clog2(UV_FRAC_BITS);

	// A span narrower than 0.001 is replaced by 1.0, both in Q.16 units.
	localparam int SPAN_MIN_LSB = 66;
	localparam int SPAN_ONE_LSB = 65536;

	typedef enum logic [1:0] {
		ACT_FIRST = 2'd0,
		ACT_MORE  = 2'd1,
		ACT_MAP   = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		action_t                        action;
		logic signed [COORD_WIDTH-1:0]  pos_x;
		logic signed [COORD_WIDTH-1:0]  pos_y;
	} uvp_in_t;

	typedef struct packed {
		logic [UV_W-1:0] tex_u;
		logic [UV_W-1:0] tex_v;
	} uvp_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic capture;
		logic div_load;
		logic div_axis;
		logic div_step;
		logic store_u;
		logic out_load;
	} uvp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_map;
	} uvp_status_t;

endpackage

### rtl/core/uvp_datapath.sv
module uvp_datapath import uvp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  uvp_in_t     in_data,
	input  uvp_cmd_t    cmd,
	output uvp_status_t status,
	output uvp_out_t    out_data
);

	logic signed [COORD_WIDTH-1:0] low_x_q, low_y_q, high_x_q, high_y_q;
	logic signed [SPAN_W-1:0]      span_x_raw, span_y_raw, diff_x_raw, diff_y_raw;
	logic        [SPAN_W-1:0]      span_x_adj, span_y_adj;
	logic        [SPAN_W-1:0]      span_x_q, span_y_q;
	logic signed [SPAN_W-1:0]      diff_x_q, diff_y_q;
	logic        [SPAN_W-1:0]      s_sel;
	logic signed [SPAN_W-1:0]      d_sel;
	logic        [SPAN_W-1:0]      rem_q, sdiv_q;
	logic        [SPAN_W:0]        rem_sh, rem_sub;
	logic                          rem_ge;
	logic        [UV_FRAC_BITS-1:0] quo_q;
	logic                          zero_q, sat_q;
	logic        [UV_W-1:0]        res, u_q;
	uvp_out_t                      out_q;

	assign status.is_map = (in_data.action == ACT_MAP);

	// Bounding box: the first vertex loads it, later vertices widen it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_x_q  <= '0;
			low_y_q  <= '0;
			high_x_q <= '0;
			high_y_q <= '0;
		end else if (cmd.accept) begin
			unique case (in_data.action)
				ACT_FIRST: begin
					low_x_q  <= in_data.pos_x;
					high_x_q <= in_data.pos_x;
					low_y_q  <= in_data.pos_y;
					high_y_q <= in_data.pos_y;
				end
				ACT_MORE: begin
					if (in_data.pos_x < low_x_q)  low_x_q  <= in_data.pos_x;
					if (in_data.pos_x > high_x_q) high_x_q <= in_data.pos_x;
					if (in_data.pos_y < low_y_q)  low_y_q  <= in_data.pos_y;
					if (in_data.pos_y > high_y_q) high_y_q <= in_data.pos_y;
				end
				default: begin
				end
			endcase
		end
	end

	// Spans and offsets, one bit wider than the coordinates.
	assign span_x_raw = $signed({high_x_q[COORD_WIDTH-1], high_x_q})
		- $signed({low_x_q[COORD_WIDTH-1], low_x_q});
	assign span_y_raw = $signed({high_y_q[COORD_WIDTH-1], high_y_q})
		- $signed({low_y_q[COORD_WIDTH-1], low_y_q});
	assign diff_x_raw = $signed({in_data.pos_x[COORD_WIDTH-1], in_data.pos_x})
		- $signed({low_x_q[COORD_WIDTH-1], low_x_q});
	assign diff_y_raw = $signed({in_data.pos_y[COORD_WIDTH-1], in_data.pos_y})
		- $signed({low_y_q[COORD_WIDTH-1], low_y_q});

	// A narrow, empty or inverted span is taken as 1.0.
	assign span_x_adj = (span_x_raw < $signed(SPAN_W'(SPAN_MIN_LSB)))
		? SPAN_W'(SPAN_ONE_LSB) : $unsigned(span_x_raw);
	assign span_y_adj = (span_y_raw < $signed(SPAN_W'(SPAN_MIN_LSB)))
		? SPAN_W'(SPAN_ONE_LSB) : $unsigned(span_y_raw);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			span_x_q <= span_x_adj;
			span_y_q <= span_y_adj;
			diff_x_q <= diff_x_raw;
			diff_y_q <= diff_y_raw;
		end
	end

	// Operand selection for the shared divider.
	assign s_sel = cmd.div_axis ? span_y_q : span_x_q;
	assign d_sel = cmd.div_axis ? diff_y_q : diff_x_q;

	// One restoring step: shift the remainder and subtract the divisor if it fits.
	assign rem_sh  = {rem_q, 1'b0};
	assign rem_sub = rem_sh - {1'b0, sdiv_q};
	assign rem_ge  = (rem_sh >= {1'b0, sdiv_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q  <= $unsigned(d_sel);
			sdiv_q <= s_sel;
			quo_q  <= '0;
			zero_q <= (d_sel <= $signed(SPAN_W'(0)));
			sat_q  <= ($unsigned(d_sel) >= s_sel);
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
			quo_q <= {quo_q[UV_FRAC_BITS-2:0], rem_ge};
		end
	end

	// Vertices at or below the box give zero, at or past its far edge give 1.0.
	assign res = zero_q ? '0 : (sat_q ? {1'b1, {UV_FRAC_BITS{1'b0}}} : {1'b0, quo_q});

	// The horizontal result is kept while the divider works on the vertical one.
	always_ff @(posedge clk) begin
		if (cmd.store_u) begin
			u_q <= res;
		end
		if (cmd.out_load) begin
			out_q.tex_u <= u_q;
			out_q.tex_v <= res;
		end
	end

	assign out_data = out_q;

endmodule

### rtl/core/uvp_ctrl.sv
`include "planar_uv_projection_top_assert.svh"

module uvp_ctrl import uvp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	input  uvp_status_t status,
	output uvp_cmd_t    cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOAD = 4'b0010,
		S_DIV  = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(UV_FRAC_BITS - 1);

	state_t           state_q, state_d;
	logic             axis_q, axis_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q, out_valid_d;
	logic             accept;

	// Input transactions are taken only between map operations.
	assign accept   = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	// Sequencer: load and divide for u, then for v, then hand over the result.
	always_comb begin
		state_d      = state_q;
		axis_d       = axis_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		cmd.accept   = accept;
		cmd.div_axis = axis_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && status.is_map) begin
					cmd.capture = 1'b1;
					axis_d      = 1'b0;
					state_d     = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.div_load = 1'b1;
				cmd.store_u  = axis_q;
				cnt_d        = '0;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == CNT_LAST) begin
					if (!axis_q) begin
						axis_d  = 1'b1;
						state_d = S_LOAD;
					end else begin
						state_d = S_DONE;
					end
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// The output register holds its transaction until the receiver takes it.
	assign out_valid_d = cmd.out_load ? 1'b1 : (out_valid_q && out_stall);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			axis_q      <= axis_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	`UVP_ASSERT(a_map_starts_u, clk, arst_n, (accept && status.is_map) |=> (state_q == S_LOAD && !axis_q), "map transaction did not start with the horizontal axis")
	`UVP_ASSERT(a_v_ends_done, clk, arst_n, (state_q == S_DIV && axis_q && cnt_q == CNT_LAST) |=> (state_q == S_DONE), "vertical division did not finish in the done state")
	`UVP_ASSERT(a_rose_after_done, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == S_DONE), "result presented without a finished division")
	`UVP_ASSERT_ALWAYS(a_cnt_range, clk, (state_q == S_DIV) |-> (cnt_q <= CNT_LAST), "division step counter out of range")

endmodule

### rtl/core/planar_uv_projection_top.sv
// Bounds transactions (first or further vertex) are taken while the block is idle.
// A map transaction occupies the block until its result is loaded: two divisions,
// each of UV_FRAC_BITS steps, run one after the other on a single restoring divider.
// The result is held in an output register until the receiver takes it.
// Asynchronous active-low reset clears the bounding box to zero and empties the output.
module planar_uv_projection_top import uvp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  uvp_in_t  in_data,
	output logic     out_valid,
	input  logic     out_stall,
	output uvp_out_t out_data
);

	uvp_cmd_t    cmd;
	uvp_status_t status;

	// Sequencing of transactions and of the divider.
	uvp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	// Bounding box, divider and output register.
	uvp_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);

endmodule
